FILE: hdl/tei_pkg.sv
// Shared types and constants of the tree ensemble inference core.
package tei_pkg;

    // Store geometry
    localparam int NODE_SLOTS   = 256;
    localparam int NODE_AW      = $clog2(NODE_SLOTS);
    localparam int NUM_TREES    = 16;
    localparam int TREE_AW      = $clog2(NUM_TREES);
    localparam int NUM_FEATURES = 64;
    localparam int FEAT_AW      = $clog2(NUM_FEATURES);
    localparam int STORE_AW     = TREE_AW + NODE_AW;
    localparam int STORE_DEPTH  = NUM_TREES * NODE_SLOTS;

    // Value and counter widths
    localparam int VAL_W    = 32;
    localparam int CNT_W    = TREE_AW + 1;
    localparam int STEP_W   = 16;
    localparam int SUM_W    = VAL_W + TREE_AW;
    localparam int DIV_CW   = $clog2(SUM_W);
    localparam int CFG_W    = 16;

    // Command queue between front and back
    localparam int CMD_DEPTH = 2;
    localparam int CMD_AW    = 1;

    // Configuration register indexes and reset values
    localparam logic CFG_TREE_COUNT = 1'b0;
    localparam logic CFG_STEP_LIMIT = 1'b1;
    localparam logic [CNT_W-1:0]  TREE_COUNT_RST = CNT_W'(1);
    localparam logic [STEP_W-1:0] STEP_LIMIT_RST = STEP_W'(1000);

    typedef enum logic [1:0] {
        OP_NODE = 2'd0,
        OP_FEAT = 2'd1,
        OP_EVAL = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NODE,
        ST_LINK,
        ST_FEAT,
        ST_DIV,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic                     leaf;
        logic [NODE_AW-1:0]       greater;
        logic [NODE_AW-1:0]       less;
        logic [FEAT_AW-1:0]       feat;
        logic signed [VAL_W-1:0]  cut;
        logic signed [VAL_W-1:0]  mean;
    } node_word_t;

    typedef struct packed {
        logic                     finite;
        logic signed [VAL_W-1:0]  value;
    } feat_word_t;

    typedef struct packed {
        op_t                  op;
        logic [STORE_AW-1:0]  node_addr;
        node_word_t           node;
        logic [FEAT_AW-1:0]   feat_slot;
        feat_word_t           feat;
    } cmd_t;

endpackage

FILE: hdl/tei_ram.sv
// Generic simple dual-port RAM with registered read.
module tei_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write one word, read one word per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

FILE: hdl/tei_front.sv
// Front part: accepts input words, drops unknown operations, queues commands.
module tei_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  tei_pkg::cmd_t in_cmd,
    output logic          cmd_valid,
    output tei_pkg::cmd_t cmd_out,
    input  logic          cmd_take
);

    tei_pkg::cmd_t               queue_reg [tei_pkg::CMD_DEPTH];
    logic [tei_pkg::CMD_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [tei_pkg::CMD_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [tei_pkg::CMD_AW:0]    count_reg, count_next;
    logic                        enq;
    logic                        deq;

    assign full      = (count_reg == (tei_pkg::CMD_AW + 1)'(tei_pkg::CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd_out   = queue_reg[rd_ptr_reg];

    // Classify: only known operations enter the queue
    assign enq = push && !full && (in_cmd.op != tei_pkg::OP_NONE);
    assign deq = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = enq ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!enq && deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued words
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            queue_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: hdl/tei_back.sv
// Back part: executes store writes, walks the trees and averages their values.
module tei_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  tei_pkg::cmd_t                     cmd,
    output logic                              cmd_take,
    input  logic [tei_pkg::CNT_W-1:0]         tree_count,
    input  logic [tei_pkg::STEP_W-1:0]        step_limit,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [tei_pkg::VAL_W-1:0]  prediction,
    output logic                              limit_reached
);

    tei_pkg::state_t                  state_reg, state_next;
    logic [tei_pkg::TREE_AW-1:0]      tree_reg, tree_next;
    logic [tei_pkg::NODE_AW-1:0]      node_reg, node_next;
    logic [tei_pkg::STEP_W-1:0]       steps_reg, steps_next;
    logic signed [tei_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic                             hit_reg, hit_next;
    logic                             neg_reg, neg_next;
    logic [tei_pkg::SUM_W-1:0]        quo_reg, quo_next;
    logic [tei_pkg::CNT_W-1:0]        rem_reg, rem_next;
    logic [tei_pkg::DIV_CW-1:0]       bit_reg, bit_next;
    logic                             out_valid_reg, out_valid_next;
    logic signed [tei_pkg::VAL_W-1:0] out_pred_reg, out_pred_next;
    logic                             out_hit_reg, out_hit_next;

    tei_pkg::node_word_t              node_q;
    tei_pkg::feat_word_t              feat_q;
    logic                             node_we;
    logic                             feat_we;
    logic signed [tei_pkg::SUM_W-1:0] sum_add;
    logic [tei_pkg::SUM_W-1:0]        sum_mag;
    logic [tei_pkg::SUM_W-1:0]        quo_signed;
    logic [tei_pkg::CNT_W:0]          trial;
    logic                             trial_ge;
    logic                             last_tree;
    logic                             tree_done;

    // Node store: cut, mean and links in one word per node
    tei_ram #(
        .WIDTH ($bits(tei_pkg::node_word_t)),
        .DEPTH (tei_pkg::STORE_DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (cmd.node_addr),
        .wdata (cmd.node),
        .raddr ({tree_reg, node_reg}),
        .rdata (node_q)
    );

    // Feature store: value and finite flag of the current observation
    tei_ram #(
        .WIDTH ($bits(tei_pkg::feat_word_t)),
        .DEPTH (tei_pkg::NUM_FEATURES)
    ) u_feat_ram (
        .clk   (clk),
        .we    (feat_we),
        .waddr (cmd.feat_slot),
        .wdata (cmd.feat),
        .raddr (node_q.feat),
        .rdata (feat_q)
    );

    assign empty         = !out_valid_reg;
    assign prediction    = out_pred_reg;
    assign limit_reached = out_hit_reg;

    // Datapath helpers
    assign sum_add    = sum_reg + {{tei_pkg::TREE_AW{node_q.mean[tei_pkg::VAL_W-1]}},
                                   node_q.mean};
    assign sum_mag    = sum_add[tei_pkg::SUM_W-1] ? -sum_add : sum_add;
    assign quo_signed = neg_reg ? -quo_reg : quo_reg;
    assign trial      = {rem_reg, quo_reg[tei_pkg::SUM_W-1]};
    assign trial_ge   = (trial >= {1'b0, tree_count});
    assign last_tree  = ({1'b0, tree_reg} == tree_count - 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        tree_next      = tree_reg;
        node_next      = node_reg;
        steps_next     = steps_reg;
        sum_next       = sum_reg;
        hit_next       = hit_reg;
        neg_next       = neg_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg && !pop;
        out_pred_next  = out_pred_reg;
        out_hit_next   = out_hit_reg;
        cmd_take       = 1'b0;
        node_we        = 1'b0;
        feat_we        = 1'b0;
        tree_done      = 1'b0;

        case (state_reg)
            // Take the next command from the queue
            tei_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take = 1'b1;
                    case (cmd.op)
                        tei_pkg::OP_NODE: node_we = 1'b1;
                        tei_pkg::OP_FEAT: feat_we = 1'b1;
                        tei_pkg::OP_EVAL:
                        begin
                            tree_next  = '0;
                            node_next  = '0;
                            steps_next = '0;
                            sum_next   = '0;
                            hit_next   = 1'b0;
                            state_next = tei_pkg::ST_NODE;
                        end
                        default: ;
                    endcase
                end
            end

            // Node address is out, data arrives next cycle
            tei_pkg::ST_NODE:
            begin
                state_next = tei_pkg::ST_LINK;
            end

            // Stop at a leaf or at the step limit, else fetch the feature
            tei_pkg::ST_LINK:
            begin
                if (node_q.leaf)
                begin
                    tree_done = 1'b1;
                end
                else if (steps_reg >= step_limit)
                begin
                    hit_next  = 1'b1;
                    tree_done = 1'b1;
                end
                else
                begin
                    state_next = tei_pkg::ST_FEAT;
                end
            end

            // Branch on the comparison, or stop at a non-finite feature
            tei_pkg::ST_FEAT:
            begin
                if (!feat_q.finite)
                begin
                    tree_done = 1'b1;
                end
                else
                begin
                    node_next  = (feat_q.value > node_q.cut) ? node_q.greater : node_q.less;
                    steps_next = steps_reg + 1'b1;
                    state_next = tei_pkg::ST_NODE;
                end
            end

            // Restoring division of the magnitude, one bit per cycle
            tei_pkg::ST_DIV:
            begin
                rem_next = trial_ge ? tei_pkg::CNT_W'(trial - {1'b0, tree_count})
                                    : tei_pkg::CNT_W'(trial);
                quo_next = {quo_reg[tei_pkg::SUM_W-2:0], trial_ge};
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    state_next = tei_pkg::ST_PUT;
                end
            end

            // Load the output register once it is free
            tei_pkg::ST_PUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_pred_next  = quo_signed[tei_pkg::VAL_W-1:0];
                    out_hit_next   = hit_reg;
                    state_next     = tei_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tei_pkg::ST_IDLE;
            end
        endcase

        // Accumulate the tree value and move to the next tree or divide
        if (tree_done)
        begin
            sum_next = sum_add;
            if (last_tree)
            begin
                neg_next   = sum_add[tei_pkg::SUM_W-1];
                quo_next   = sum_mag;
                rem_next   = '0;
                bit_next   = tei_pkg::DIV_CW'(tei_pkg::SUM_W - 1);
                state_next = tei_pkg::ST_DIV;
            end
            else
            begin
                tree_next  = tree_reg + 1'b1;
                node_next  = '0;
                steps_next = '0;
                state_next = tei_pkg::ST_NODE;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tei_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk and division registers
    always_ff @(posedge clk)
    begin
        tree_reg     <= tree_next;
        node_reg     <= node_next;
        steps_reg    <= steps_next;
        sum_reg      <= sum_next;
        hit_reg      <= hit_next;
        neg_reg      <= neg_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        bit_reg      <= bit_next;
        out_pred_reg <= out_pred_next;
        out_hit_reg  <= out_hit_next;
    end

endmodule

FILE: hdl/tree_ensemble_inference_core.sv
// Top level of the regression-forest inference core.
//
// Input side is a queue: drive a word and raise push; it is taken at a rising
// edge where full is low. A word writes one tree node, writes one observation
// feature, or asks for an evaluation; operation code 3 is taken and dropped.
// Result side is a single register: while empty is low, prediction and
// limit_reached show the waiting result; pop takes it.
// Configuration writes (cfg_index 0 tree count, 1 step limit) are always
// taken (cfg_ready high) and should be made while the core is idle.
// Node and feature writes are done by the back end in its idle state. An
// evaluation walks each branch step through ST_NODE, ST_LINK and ST_FEAT; a
// tree ends in ST_LINK at a leaf or the step limit, or in ST_FEAT at a
// missing feature. The sum is divided by the tree count, and ST_PUT loads the
// quotient when the output is free. The node store read sets the step rate.
// A two-word command queue lets new words in while an evaluation runs, and
// the result register holds a finished word while the receiver stalls.
// Reset empties the queues and restores tree count 1 and step limit 1000;
// node and feature stores keep no reset value and must be written first.
module tree_ensemble_inference_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        operation,
    input  logic [3:0]                        tree_index,
    input  logic [7:0]                        node_index,
    input  logic [5:0]                        split_feature,
    input  logic signed [31:0]                split_threshold,
    input  logic [7:0]                        less_child,
    input  logic [7:0]                        greater_child,
    input  logic                              leaf_flag,
    input  logic signed [31:0]                node_mean,
    input  logic [5:0]                        feature_slot,
    input  logic signed [31:0]                feature_value,
    input  logic                              feature_finite,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [31:0]                prediction,
    output logic                              limit_reached,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [tei_pkg::CFG_W-1:0]         cfg_data
);

    logic [tei_pkg::CNT_W-1:0]   tree_count_reg;
    logic [tei_pkg::STEP_W-1:0]  step_limit_reg;
    logic [tei_pkg::CNT_W-1:0]   count_eff;
    tei_pkg::cmd_t               in_cmd;
    tei_pkg::cmd_t               cmd;
    logic                        cmd_valid;
    logic                        cmd_take;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_count_reg <= tei_pkg::TREE_COUNT_RST;
            step_limit_reg <= tei_pkg::STEP_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == tei_pkg::CFG_TREE_COUNT)
            begin
                tree_count_reg <= cfg_data[tei_pkg::CNT_W-1:0];
            end
            else
            begin
                step_limit_reg <= cfg_data[tei_pkg::STEP_W-1:0];
            end
        end
    end

    // Clamp tree count to one up to the number of trees
    always_comb
    begin
        if (tree_count_reg == '0)
        begin
            count_eff = tei_pkg::CNT_W'(1);
        end
        else if (tree_count_reg > tei_pkg::CNT_W'(tei_pkg::NUM_TREES))
        begin
            count_eff = tei_pkg::CNT_W'(tei_pkg::NUM_TREES);
        end
        else
        begin
            count_eff = tree_count_reg;
        end
    end

    // Pack the input word
    always_comb
    begin
        in_cmd.op           = tei_pkg::op_t'(operation);
        in_cmd.node_addr    = {tree_index, node_index};
        in_cmd.node.leaf    = leaf_flag;
        in_cmd.node.greater = greater_child;
        in_cmd.node.less    = less_child;
        in_cmd.node.feat    = split_feature;
        in_cmd.node.cut     = split_threshold;
        in_cmd.node.mean    = node_mean;
        in_cmd.feat_slot    = feature_slot;
        in_cmd.feat.finite  = feature_finite;
        in_cmd.feat.value   = feature_value;
    end

    tei_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd_out   (cmd),
        .cmd_take  (cmd_take)
    );

    tei_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_take      (cmd_take),
        .tree_count    (count_eff),
        .step_limit    (step_limit_reg),
        .empty         (empty),
        .pop           (pop),
        .prediction    (prediction),
        .limit_reached (limit_reached)
    );

endmodule

FILE: hdl/tei_checker.sv
// Port-level checker for the inference core, bound to the top level.
module tei_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] prediction,
    input logic        limit_reached
);

    // Hold a waiting result until it is popped
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(prediction) && $stable(limit_reached)))
        else $error("waiting result changed or vanished");

    // Fill the input queue only through an accepted word
    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("input queue filled without a push");

    // Drop everything during reset
    a_reset_clears: assert property (@(posedge clk)
        !rst_n |=> (empty && !full))
        else $error("queues not cleared during reset");

endmodule

bind tree_ensemble_inference_core tei_checker u_tei_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .prediction    (prediction),
    .limit_reached (limit_reached)
);
